/* rtl/necir_pkg.sv */
// Shared types, codes and a helper function for the NEC infrared pulse decoder.
package necir_pkg;

	// Widths of the fixed fields.
	localparam int unsigned IntervalW = 20;
	localparam int unsigned BoundW    = 16;
	localparam int unsigned WordW     = 32;
	localparam int unsigned StatusW   = 2;
	localparam int unsigned RegIdxW   = 3;

	// Result status codes.
	typedef enum logic [StatusW-1:0] {
		ST_FULL  = 2'd0,
		ST_HOLD  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	// Configuration register indexes.
	typedef enum logic [RegIdxW-1:0] {
		REG_HOLD_MIN = 3'd0,
		REG_HOLD_MAX = 3'd1,
		REG_FULL_MIN = 3'd2,
		REG_FULL_MAX = 3'd3,
		REG_ONE_MIN  = 3'd4,
		REG_ONE_MAX  = 3'd5,
		REG_ZERO_MIN = 3'd6,
		REG_ZERO_MAX = 3'd7
	} reg_idx_t;

	// Reset values of the timing windows, in microseconds.
	localparam logic [BoundW-1:0] HoldMinRst = 16'd2000;
	localparam logic [BoundW-1:0] HoldMaxRst = 16'd2500;
	localparam logic [BoundW-1:0] FullMinRst = 16'd4000;
	localparam logic [BoundW-1:0] FullMaxRst = 16'd5000;
	localparam logic [BoundW-1:0] OneMinRst  = 16'd1400;
	localparam logic [BoundW-1:0] OneMaxRst  = 16'd2000;
	localparam logic [BoundW-1:0] ZeroMinRst = 16'd300;
	localparam logic [BoundW-1:0] ZeroMaxRst = 16'd800;

	// Decoder phase, one-hot.
	typedef enum logic [2:0] {
		PH_IDLE     = 3'b001,
		PH_PREAMBLE = 3'b010,
		PH_DATA     = 3'b100
	} phase_t;

	// All timing windows as the core sees them.
	typedef struct packed {
		logic [BoundW-1:0] hold_min;
		logic [BoundW-1:0] hold_max;
		logic [BoundW-1:0] full_min;
		logic [BoundW-1:0] full_max;
		logic [BoundW-1:0] one_min;
		logic [BoundW-1:0] one_max;
		logic [BoundW-1:0] zero_min;
		logic [BoundW-1:0] zero_max;
	} windows_t;

	// One decoded result.
	typedef struct packed {
		status_t           status;
		logic [WordW-1:0]  frame_word;
	} result_t;

	// Strict window test: lo < v < hi.
	function automatic logic win_hit(
		input logic [IntervalW-1:0] v,
		input logic [BoundW-1:0]    lo,
		input logic [BoundW-1:0]    hi
	);
		logic [IntervalW-1:0] lo_x;
		logic [IntervalW-1:0] hi_x;
		lo_x = IntervalW'(lo);
		hi_x = IntervalW'(hi);
		return (v > lo_x) && (v < hi_x);
	endfunction

endpackage

/* rtl/necir_core.sv */
// Frame state machine: classifies one edge interval per cycle while take is high and forms results.
module necir_core #(
	parameter int unsigned EDGES_PER_FRAME = 65,
	parameter int unsigned FRAME_BITS      = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic [necir_pkg::IntervalW-1:0]   interval_us,
	input  necir_pkg::windows_t               win,
	output logic                              res_valid,
	output necir_pkg::result_t                res
);
	import necir_pkg::*;

	// The edge counter must reach EDGES_PER_FRAME - 1 and the hold count of 3.
	localparam int unsigned CntW = ($clog2(EDGES_PER_FRAME) < 2) ? 2 : $clog2(EDGES_PER_FRAME);
	// The bit position is compared in a width that also holds FRAME_BITS.
	localparam int unsigned PosW = (CntW > 6) ? CntW : 6;
	localparam logic [CntW-1:0] LastEdge = CntW'(EDGES_PER_FRAME - 1);
	localparam logic [PosW-1:0] FrameBits = PosW'(FRAME_BITS);
	localparam logic [CntW-1:0] CntOne   = CntW'(1);
	localparam logic [CntW-1:0] CntTwo   = CntW'(2);
	localparam logic [CntW-1:0] CntThree = CntW'(3);

	phase_t            phase_q, phase_d;
	logic [CntW-1:0]   edge_count_q, edge_count_d;
	logic [WordW-1:0]  bit_shift_q, bit_shift_d;
	logic              bad_bit_q, bad_bit_d;
	logic [CntW-1:0]   pos;
	logic              one_hit;
	logic              zero_hit;

	assign pos      = edge_count_q >> 1;
	assign one_hit  = win_hit(interval_us, win.one_min, win.one_max);
	assign zero_hit = win_hit(interval_us, win.zero_min, win.zero_max);

	// Next state and result for the request being taken.
	always_comb begin
		phase_d        = phase_q;
		edge_count_d   = edge_count_q;
		bit_shift_d    = bit_shift_q;
		bad_bit_d      = bad_bit_q;
		res_valid      = 1'b0;
		res.status     = ST_ERROR;
		res.frame_word = '0;
		unique case (phase_q)
			PH_PREAMBLE: begin
				if (edge_count_q == CntOne) begin
					edge_count_d = CntTwo;
				end else if (edge_count_q == CntTwo) begin
					if (win_hit(interval_us, win.hold_min, win.hold_max)) begin
						edge_count_d = CntThree;
					end else if (win_hit(interval_us, win.full_min, win.full_max)) begin
						phase_d      = PH_DATA;
						edge_count_d = '0;
						bit_shift_d  = '0;
						bad_bit_d    = 1'b0;
					end else begin
						res_valid    = 1'b1;
						res.status   = ST_ERROR;
						phase_d      = PH_IDLE;
						edge_count_d = '0;
					end
				end else begin
					res_valid    = 1'b1;
					res.status   = ST_HOLD;
					phase_d      = PH_IDLE;
					edge_count_d = '0;
				end
			end
			PH_DATA: begin
				if (edge_count_q >= LastEdge) begin
					res_valid    = 1'b1;
					phase_d      = PH_IDLE;
					edge_count_d = '0;
					if (bad_bit_q) begin
						res.status = ST_ERROR;
					end else begin
						res.status     = ST_FULL;
						res.frame_word = bit_shift_q;
					end
				end else begin
					// Odd intervals carry the data bits, LSB first.
					if (edge_count_q[0] && (PosW'(pos) < FrameBits)) begin
						if (one_hit) begin
							bit_shift_d = bit_shift_q | (WordW'(1) << pos);
						end else if (!zero_hit) begin
							bad_bit_d = 1'b1;
						end
					end
					edge_count_d = edge_count_q + CntOne;
				end
			end
			default: begin
				// Idle, or an unused phase code: this edge opens a frame.
				phase_d      = PH_PREAMBLE;
				edge_count_d = CntOne;
			end
		endcase
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			edge_count_q <= '0;
			bit_shift_q  <= '0;
			bad_bit_q    <= 1'b0;
		end else if (take) begin
			phase_q      <= phase_d;
			edge_count_q <= edge_count_d;
			bit_shift_q  <= bit_shift_d;
			bad_bit_q    <= bad_bit_d;
		end
	end

endmodule

/* rtl/nec_ir_pulse_decoder.sv */
// Top level of the NEC infrared pulse decoder: configuration, core and output buffer.
//
//  Channel  Handshake               Payload
//  in       in_valid / in_stall     interval_us
//  out      out_valid / out_stall   status, frame_word
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each edge request is classified in the cycle it is taken; one request per cycle while in_stall is low.
// A result is registered in the output buffer before it appears on the output.
// A two-entry output buffer lets requests flow while a result waits; in_stall
// rises only when both entries are full. cfg_ready is always high.
// Reset restores the default timing windows and returns the decoder to idle.
module nec_ir_pulse_decoder #(
	parameter int unsigned EDGES_PER_FRAME = 65,
	parameter int unsigned FRAME_BITS      = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [necir_pkg::IntervalW-1:0]   interval_us,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [necir_pkg::StatusW-1:0]     status,
	output logic [necir_pkg::WordW-1:0]       frame_word,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [necir_pkg::RegIdxW-1:0]     cfg_index,
	input  logic [necir_pkg::BoundW-1:0]      cfg_data
);
	import necir_pkg::*;

	windows_t  win_q;
	logic      take;
	logic      res_valid;
	result_t   res;
	logic      main_valid_q;
	result_t   main_q;
	logic      skid_valid_q;
	result_t   skid_q;
	logic      pop;

	assign cfg_ready = 1'b1;

	// Timing window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.hold_min <= HoldMinRst;
			win_q.hold_max <= HoldMaxRst;
			win_q.full_min <= FullMinRst;
			win_q.full_max <= FullMaxRst;
			win_q.one_min  <= OneMinRst;
			win_q.one_max  <= OneMaxRst;
			win_q.zero_min <= ZeroMinRst;
			win_q.zero_max <= ZeroMaxRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HOLD_MIN: win_q.hold_min <= cfg_data;
				REG_HOLD_MAX: win_q.hold_max <= cfg_data;
				REG_FULL_MIN: win_q.full_min <= cfg_data;
				REG_FULL_MAX: win_q.full_max <= cfg_data;
				REG_ONE_MIN:  win_q.one_min  <= cfg_data;
				REG_ONE_MAX:  win_q.one_max  <= cfg_data;
				REG_ZERO_MIN: win_q.zero_min <= cfg_data;
				REG_ZERO_MAX: win_q.zero_max <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = skid_valid_q;
	assign take     = in_valid && !in_stall;

	necir_core #(
		.EDGES_PER_FRAME (EDGES_PER_FRAME),
		.FRAME_BITS      (FRAME_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.interval_us (interval_us),
		.win         (win_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Output buffer: main entry drives the port, skid entry catches a result
	// produced while the main one is held.
	assign pop = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !main_valid_q) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= take && res_valid;
			end else begin
				main_valid_q <= take && res_valid;
			end
		end else if (take && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_valid_q) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				skid_q <= res;
			end else begin
				main_q <= res;
			end
		end else if (take && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid  = main_valid_q;
	assign status     = main_q.status;
	assign frame_word = main_q.frame_word;

endmodule

/* test/nec_ir_pulse_decoder_test.sv */
// Self-checking testbench for the NEC infrared pulse decoder: directed edges, then random frames.
module nec_ir_pulse_decoder_test;
	import necir_pkg::*;

	localparam int unsigned EdgesPerFrame = 65;
	localparam int unsigned FrameBits     = 32;
	localparam int unsigned CycleLimit    = 200000;
	localparam int unsigned DrainCycles   = 8;
	localparam int unsigned HoldOffCycles = 400;
	localparam int unsigned HoldOffFrames = 30;
	localparam int unsigned SegmentEdges  = 60;
	localparam int unsigned SegmentCount  = 8;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

	// One directed edge; typed rows carry their own expected result.
	typedef struct packed {
		logic [IntervalW-1:0] interval;
		logic                 typed;
		status_t              st;
		logic [WordW-1:0]     word;
	} edge_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [IntervalW-1:0] interval_us;
	logic                 out_valid;
	logic                 out_stall;
	logic [StatusW-1:0]   status;
	logic [WordW-1:0]     frame_word;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [RegIdxW-1:0]   cfg_index;
	logic [BoundW-1:0]    cfg_data;

	nec_ir_pulse_decoder #(
		.EDGES_PER_FRAME(EdgesPerFrame),
		.FRAME_BITS     (FrameBits)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.interval_us(interval_us),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.frame_word (frame_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Timing windows and decoder state as the testbench tracks them.
	windows_t bounds = '{HoldMinRst, HoldMaxRst, FullMinRst, FullMaxRst,
		OneMinRst, OneMaxRst, ZeroMinRst, ZeroMaxRst};
	phase_t           dec_phase = PH_IDLE;
	logic [6:0]       dec_count = '0;
	logic [WordW-1:0] dec_bits  = '0;
	logic             dec_bad   = 1'b0;

	result_t     pending_decodes [$];
	logic        pin_on         = 1'b0;
	result_t     pin_result     = '0;
	logic        staged_pin     = 1'b0;
	result_t     staged_result  = '0;
	int          fails          = 0;
	int unsigned sent_edges     = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left      = 0;
	int unsigned cycle_count    = 0;

	// Directed edges at reset windows: hold frames, unchecked second interval, exclusive
	// bounds of the preamble space and intervals too wide for any window.
	edge_row_t directed_edges [23] = '{
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'hFFFFF,  1'b0, ST_FULL,  32'd0},
		'{20'd2250,   1'b0, ST_FULL,  32'd0},
		'{20'd0,      1'b1, ST_HOLD,  32'd0},
		'{20'hFFFFF,  1'b0, ST_FULL,  32'd0},
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'd2001,   1'b0, ST_FULL,  32'd0},
		'{20'hFFFFF,  1'b1, ST_HOLD,  32'd0},
		'{20'd123,    1'b0, ST_FULL,  32'd0},
		'{20'd456,    1'b0, ST_FULL,  32'd0},
		'{20'd2000,   1'b1, ST_ERROR, 32'd0},
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'd2500,   1'b1, ST_ERROR, 32'd0},
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'd4000,   1'b1, ST_ERROR, 32'd0},
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'd65536,  1'b1, ST_ERROR, 32'd0},
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'd0,      1'b0, ST_FULL,  32'd0},
		'{20'hFFFFF,  1'b1, ST_ERROR, 32'd0}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Strict window test on the full interval width.
	function automatic logic fits(input logic [IntervalW-1:0] v, input logic [BoundW-1:0] lo,
		input logic [BoundW-1:0] hi);
		return (v > IntervalW'(lo)) && (v < IntervalW'(hi));
	endfunction

	function automatic void apply_reg(input reg_idx_t idx, input logic [BoundW-1:0] data);
		case (idx)
			REG_HOLD_MIN: bounds.hold_min = data;
			REG_HOLD_MAX: bounds.hold_max = data;
			REG_FULL_MIN: bounds.full_min = data;
			REG_FULL_MAX: bounds.full_max = data;
			REG_ONE_MIN:  bounds.one_min  = data;
			REG_ONE_MAX:  bounds.one_max  = data;
			REG_ZERO_MIN: bounds.zero_min = data;
			REG_ZERO_MAX: bounds.zero_max = data;
			default: ;
		endcase
	endfunction

	// Advances the tracked decoder by one edge and tells whether it ends a frame.
	function automatic void decode_edge(input logic [IntervalW-1:0] iv, output logic emits,
		output result_t res);
		emits = 1'b0;
		res = '0;
		res.status = ST_FULL;
		case (dec_phase)
			PH_PREAMBLE: begin
				if (dec_count == 7'd1) begin
					dec_count = 7'd2;
				end else if (dec_count == 7'd2) begin
					// The hold window is tested first, so it wins where the two overlap.
					if (fits(iv, bounds.hold_min, bounds.hold_max)) begin
						dec_count = 7'd3;
					end else if (fits(iv, bounds.full_min, bounds.full_max)) begin
						dec_phase = PH_DATA;
						dec_count = '0;
						dec_bits  = '0;
						dec_bad   = 1'b0;
					end else begin
						emits = 1'b1;
						res.status = ST_ERROR;
					end
				end else begin
					emits = 1'b1;
					res.status = ST_HOLD;
				end
			end
			PH_DATA: begin
				if (dec_count >= EdgesPerFrame - 1) begin
					emits = 1'b1;
					if (dec_bad) begin
						res.status = ST_ERROR;
					end else begin
						res.frame_word = dec_bits;
					end
				end else begin
					// Only odd intervals carry bits; a one wins over an overlapping zero.
					if (dec_count[0] && (dec_count >> 1) < FrameBits) begin
						if (fits(iv, bounds.one_min, bounds.one_max)) begin
							dec_bits[dec_count >> 1] = 1'b1;
						end else if (!fits(iv, bounds.zero_min, bounds.zero_max)) begin
							dec_bad = 1'b1;
						end
					end
					dec_count = dec_count + 7'd1;
				end
			end
			default: begin
				dec_phase = PH_PREAMBLE;
				dec_count = 7'd1;
			end
		endcase
		if (emits) begin
			dec_phase = PH_IDLE;
			dec_count = '0;
		end
	endfunction

	// Tracks accepted requests and configuration writes and checks every accepted result.
	always @(posedge clk) begin : check_results
		logic    emits;
		result_t predicted;
		result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_edge(interval_us, emits, predicted);
				if (pin_on) begin
					pending_decodes.push_back(pin_result);
				end else if (emits) begin
					pending_decodes.push_back(predicted);
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_decodes.size() == 0) begin
					$error("unexpected result: status %0d, frame_word %h", status, frame_word);
					fails++;
				end else begin
					want = pending_decodes.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fails++;
					end
					if (frame_word !== want.frame_word) begin
						$error("frame_word: expected %h, actual %h", want.frame_word, frame_word);
						fails++;
					end
				end
			end
			// Windows written at this edge apply from the next request on.
			if (cfg_valid && cfg_ready) begin
				apply_reg(reg_idx_t'(cfg_index), cfg_data);
			end
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	initial begin : result_sink
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL nec_ir_pulse_decoder");
		$finish;
	end

	function automatic logic [IntervalW-1:0] rand_interval();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return IntervalW'(65535);
			3: return IntervalW'(65536);
			4: return IntervalW'($urandom_range(65535));
			default: return IntervalW'($urandom);
		endcase
	endfunction

	// An interval strictly inside the window, or any interval when the window is empty.
	function automatic logic [IntervalW-1:0] pick_in(input logic [BoundW-1:0] lo,
		input logic [BoundW-1:0] hi);
		int unsigned l;
		int unsigned h;
		l = lo;
		h = hi;
		if (h > l + 1) begin
			return IntervalW'($urandom_range(h - 1, l + 1));
		end
		return rand_interval();
	endfunction

	// A random {min, max} pair, now and then an arbitrary one that may be empty.
	function automatic logic [2*BoundW-1:0] rand_window();
		int unsigned lo;
		int unsigned hi;
		if ($urandom_range(9) == 0) begin
			return $urandom;
		end
		lo = $urandom_range(63000);
		hi = lo + $urandom_range(2500, 2);
		return {BoundW'(lo), BoundW'(hi)};
	endfunction

	task automatic set_idling(input idling_t mode);
		@(posedge clk);
		send_idle_pct  = (mode == IDLE_SENDER) ? 46 : (mode == IDLE_BOTH) ? 7 : 0;
		recv_stall_pct = (mode == IDLE_RECEIVER) ? 46 : (mode == IDLE_BOTH) ? 7 : 0;
	endtask

	// Offers one edge request and returns at the edge that takes it.
	task automatic send_edge(input logic [IntervalW-1:0] iv);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		pin_on     = staged_pin;
		pin_result = staged_result;
		in_valid    <= 1'b1;
		interval_us <= iv;
		sent_edges++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_decodes.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// Writes all eight registers, in the order of the window struct fields.
	task automatic write_windows(input windows_t w);
		for (int i = REG_HOLD_MIN; i <= REG_ZERO_MAX; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= w[(REG_ZERO_MAX - i) * BoundW +: BoundW];
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_hold_frame();
		send_edge(rand_interval());
		send_edge(rand_interval());
		send_edge(pick_in(bounds.hold_min, bounds.hold_max));
		send_edge(rand_interval());
	endtask

	// Preamble, then a mark and a classed space per bit, then the closing edge.
	task automatic send_full_frame(input logic [WordW-1:0] word, input int unsigned bad_pct);
		send_edge(rand_interval());
		send_edge(rand_interval());
		send_edge(pick_in(bounds.full_min, bounds.full_max));
		for (int b = 0; b < FrameBits; b++) begin
			send_edge(rand_interval());
			if ($urandom_range(99) < bad_pct) begin
				send_edge(rand_interval());
			end else if (word[b]) begin
				send_edge(pick_in(bounds.one_min, bounds.one_max));
			end else begin
				send_edge(pick_in(bounds.zero_min, bounds.zero_max));
			end
		end
		send_edge(rand_interval());
	endtask

	// A preamble space on a window bound or anywhere at all.
	task automatic send_broken_preamble();
		send_edge(rand_interval());
		send_edge(rand_interval());
		case ($urandom_range(4))
			0: send_edge(bounds.hold_min);
			1: send_edge(bounds.hold_max);
			2: send_edge(bounds.full_min);
			3: send_edge(bounds.full_max);
			default: send_edge(rand_interval());
		endcase
	endtask

	task automatic run_traffic(input int unsigned n);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = sent_edges + n;
		while (sent_edges < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				send_full_frame($urandom, (pick < 12) ? 4 : 0);
			end else if (pick < 75) begin
				send_hold_frame();
			end else if (pick < 88) begin
				send_broken_preamble();
			end else begin
				send_edge(rand_interval());
			end
		end
		// Close whatever frame the stray edges left open.
		stop_sending();
		while (dec_phase != PH_IDLE) begin
			send_edge(rand_interval());
			stop_sending();
		end
	endtask

	initial begin : stimulus
		windows_t plan [4];
		windows_t w;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		interval_us = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		plan[0] = '{HoldMinRst, HoldMaxRst, FullMinRst, FullMaxRst,
			OneMinRst, OneMaxRst, ZeroMinRst, ZeroMaxRst};
		// Hold overlaps full, one overlaps zero.
		plan[1] = '{16'd2000, 16'd5000, 16'd3000, 16'd6000, 16'd300, 16'd2000, 16'd200, 16'd900};
		// Hold can never match; the other windows take every interval from 1 to 65534.
		plan[2] = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
		// Nothing matches at all.
		plan[3] = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed table, then frames of all ones, all zeros and one with bad spaces.
		for (int r = 0; r < $size(directed_edges); r++) begin
			staged_pin = directed_edges[r].typed;
			staged_result.status     = directed_edges[r].st;
			staged_result.frame_word = directed_edges[r].word;
			send_edge(directed_edges[r].interval);
		end
		staged_pin = 1'b0;
		send_full_frame('1, 0);
		send_full_frame('0, 0);
		send_full_frame($urandom, 3);
		stop_sending();
		wait_drained();

		// Results pile up behind a long hold-off until the input stalls.
		@(posedge clk);
		hold_left = HoldOffCycles;
		for (int k = 0; k < HoldOffFrames; k++) begin
			send_hold_frame();
		end
		stop_sending();
		wait_drained();

		// Random frames under each window setting and each idling pattern.
		for (int s = 0; s < SegmentCount; s++) begin
			w = (s < 4) ? plan[s] : {rand_window(), rand_window(), rand_window(), rand_window()};
			write_windows(w);
			set_idling(idling_t'(s % 4));
			run_traffic(SegmentEdges);
			wait_drained();
		end

		if (fails == 0 && pending_decodes.size() == 0) begin
			$display("PASS nec_ir_pulse_decoder");
		end else begin
			$display("FAIL nec_ir_pulse_decoder");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/necir_pkg.sv
rtl/necir_core.sv
rtl/nec_ir_pulse_decoder.sv
test/nec_ir_pulse_decoder_test.sv
